// ===== src/nlp_pkg.sv =====
// Package for the number literal parser: codes, character constants and the result type.
package nlp_pkg;

  // Width of the value field on the result channel
  localparam int OUT_VALUE_W = 32;

  // Parse phase
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_FIRST  = 3'd1,
    PH_SECOND = 3'd2,
    PH_BODY   = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  // Prefix seen at the head of the body
  typedef enum logic [1:0] {
    PK_NONE   = 2'd0,
    PK_0X     = 2'd1,
    PK_AMPH   = 2'd2,
    PK_DOLLAR = 2'd3
  } prefix_t;

  // Format code reported with the value
  typedef enum logic [2:0] {
    FMT_DEC    = 3'd0,
    FMT_0X     = 3'd1,
    FMT_AMPH   = 3'd2,
    FMT_DOLLAR = 3'd3,
    FMT_SUFFIX = 3'd4
  } format_t;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A_UP   = 8'h41;
  localparam logic [7:0] CH_F_UP   = 8'h46;
  localparam logic [7:0] CH_H_UP   = 8'h48;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_Z_UP   = 8'h5a;
  localparam logic [7:0] CH_A_LO   = 8'h61;
  localparam logic [7:0] CH_F_LO   = 8'h66;
  localparam logic [7:0] CH_H_LO   = 8'h68;
  localparam logic [7:0] CH_X_LO   = 8'h78;
  localparam logic [7:0] CH_Z_LO   = 8'h7a;

  // One parse result
  typedef struct packed {
    logic signed [OUT_VALUE_W-1:0] value;
    format_t                       format;
  } res_t;

endpackage

// ===== src/nlp_if.sv =====
// Valid/ready channel interfaces for characters in and results out.
interface nlp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       is_end;

  modport source (output valid, output ch, output is_end, input ready);
  modport sink   (input valid, input ch, input is_end, output ready);
endinterface

interface nlp_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [nlp_pkg::OUT_VALUE_W-1:0] value;
  logic [2:0]                            format;

  modport source (output valid, output value, output format, input ready);
  modport sink   (input valid, input value, input format, output ready);
endinterface

// ===== src/nlp_core.sv =====
// Parse state and per-character update; presents the result for an end item.
module nlp_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    ch,
  input  logic          is_end,
  output nlp_pkg::res_t res
);
  import nlp_pkg::*;

  localparam int VW = VALUE_WIDTH;

  phase_t        phase, phase_next;
  logic          negative, negative_next;
  logic [7:0]    held_char, held_char_next;
  prefix_t       prefix_kind, prefix_kind_next;
  logic [VW-1:0] dec_accum, dec_accum_next;
  logic          dec_stopped, dec_stopped_next;
  logic [VW-1:0] hex_accum, hex_accum_next;
  logic          hex_stopped, hex_stopped_next;
  logic          suffix_found, suffix_found_next;
  logic          prev_was_h, prev_was_h_next;

  // Character classes
  logic       is_dec, is_hex_lo, is_hex_up, is_hex, is_alnum, is_h;
  logic [3:0] hex_dig;
  assign is_dec    = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_hex_lo = (ch >= CH_A_LO) && (ch <= CH_F_LO);
  assign is_hex_up = (ch >= CH_A_UP) && (ch <= CH_F_UP);
  assign is_hex    = is_dec || is_hex_lo || is_hex_up;
  assign is_alnum  = is_dec || ((ch >= CH_A_LO) && (ch <= CH_Z_LO)) ||
                     ((ch >= CH_A_UP) && (ch <= CH_Z_UP));
  assign is_h      = (ch == CH_H_LO) || (ch == CH_H_UP);
  assign hex_dig   = is_dec ? ch[3:0] : (ch[3:0] + 4'd9);

  // Body digit step: x*10 as two shifts and an add, x*16 as a shift
  logic [VW-1:0] dec_fed, hex_fed;
  logic          dec_stop_fed, hex_stop_fed, suffix_fed;
  always_comb begin
    dec_fed      = dec_accum;
    dec_stop_fed = dec_stopped;
    if (!dec_stopped) begin
      if (is_dec) begin
        dec_fed = (dec_accum << 3) + (dec_accum << 1) + VW'(ch[3:0]);
      end else begin
        dec_stop_fed = 1'b1;
      end
    end
    hex_fed      = hex_accum;
    hex_stop_fed = hex_stopped;
    if (!hex_stopped) begin
      if (is_hex) begin
        hex_fed = {hex_accum[VW-5:0], hex_dig};
      end else begin
        hex_stop_fed = 1'b1;
      end
    end
    suffix_fed = suffix_found || (prev_was_h && !is_alnum);
  end

  // Next state
  logic feed;
  always_comb begin
    phase_next        = phase;
    negative_next     = negative;
    held_char_next    = held_char;
    prefix_kind_next  = prefix_kind;
    dec_accum_next    = dec_accum;
    dec_stopped_next  = dec_stopped;
    hex_accum_next    = hex_accum;
    hex_stopped_next  = hex_stopped;
    suffix_found_next = suffix_found;
    prev_was_h_next   = prev_was_h;
    feed              = 1'b0;
    if (is_end) begin
      phase_next        = PH_START;
      negative_next     = 1'b0;
      held_char_next    = CH_NUL;
      prefix_kind_next  = PK_NONE;
      dec_accum_next    = '0;
      dec_stopped_next  = 1'b0;
      hex_accum_next    = '0;
      hex_stopped_next  = 1'b0;
      suffix_found_next = 1'b0;
      prev_was_h_next   = 1'b0;
    end else if (phase != PH_DONE) begin
      if (ch == CH_NUL) begin
        phase_next = PH_DONE;
      end else begin
        unique case (phase)
          PH_START, PH_FIRST: begin
            if (phase == PH_START && ch == CH_MINUS) begin
              negative_next = 1'b1;
              phase_next    = PH_FIRST;
            end else if (ch == CH_DOLLAR) begin
              prefix_kind_next = PK_DOLLAR;
              phase_next       = PH_BODY;
            end else begin
              feed = 1'b1;
              if (ch == CH_ZERO || ch == CH_AMP) begin
                held_char_next = ch;
                phase_next     = PH_SECOND;
              end else begin
                phase_next = PH_BODY;
              end
            end
          end
          PH_SECOND: begin
            // Second character of 0x or &h restarts the hex reading
            if (held_char == CH_ZERO && (ch == CH_X_LO || ch == CH_X_UP)) begin
              prefix_kind_next = PK_0X;
              hex_accum_next   = '0;
              hex_stopped_next = 1'b0;
            end else if (held_char == CH_AMP && is_h) begin
              prefix_kind_next = PK_AMPH;
              hex_accum_next   = '0;
              hex_stopped_next = 1'b0;
            end else begin
              feed = 1'b1;
            end
            phase_next = PH_BODY;
          end
          default: begin
            feed = 1'b1;
          end
        endcase
      end
    end
    if (feed) begin
      dec_accum_next    = dec_fed;
      dec_stopped_next  = dec_stop_fed;
      hex_accum_next    = hex_fed;
      hex_stopped_next  = hex_stop_fed;
      suffix_found_next = suffix_fed;
      prev_was_h_next   = is_h;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      negative     <= 1'b0;
      held_char    <= CH_NUL;
      prefix_kind  <= PK_NONE;
      dec_accum    <= '0;
      dec_stopped  <= 1'b0;
      hex_accum    <= '0;
      hex_stopped  <= 1'b0;
      suffix_found <= 1'b0;
      prev_was_h   <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      negative     <= negative_next;
      held_char    <= held_char_next;
      prefix_kind  <= prefix_kind_next;
      dec_accum    <= dec_accum_next;
      dec_stopped  <= dec_stopped_next;
      hex_accum    <= hex_accum_next;
      hex_stopped  <= hex_stopped_next;
      suffix_found <= suffix_found_next;
      prev_was_h   <= prev_was_h_next;
    end
  end

  // Result from the current state: pick reading, apply sign
  logic [VW-1:0]          sel_val, signed_val;
  format_t                res_fmt;
  logic [OUT_VALUE_W-1:0] res_val;
  always_comb begin
    if (prefix_kind != PK_NONE) begin
      sel_val = hex_accum;
      res_fmt = format_t'({1'b0, prefix_kind});
    end else if (suffix_found || prev_was_h) begin
      sel_val = hex_accum;
      res_fmt = FMT_SUFFIX;
    end else begin
      sel_val = dec_accum;
      res_fmt = FMT_DEC;
    end
    signed_val = negative ? (VW'(0) - sel_val) : sel_val;
  end

  // Fit to the 32-bit field: sign-extend narrow widths, keep low bits of wide ones
  generate
    if (VW >= OUT_VALUE_W) begin : g_trunc
      assign res_val = signed_val[OUT_VALUE_W-1:0];
    end else begin : g_sext
      assign res_val = {{(OUT_VALUE_W-VW){signed_val[VW-1]}}, signed_val};
    end
  endgenerate

  assign res = {res_val, res_fmt};

endmodule

// ===== src/number_literal_parser_top.sv =====
// Top level of the number literal parser: handshake, result register and skid stage.
//
//   channel  dir  payload              transfer
//   chars    in   ch[7:0], is_end      valid && ready
//   result   out  value[31:0], format  valid && ready
//
// One character per cycle while chars.ready is high; an end item's result is
// registered in the output register, or in the skid stage while the output
// stalls. Synchronous reset returns the parser to the start of a literal and
// empties the output. A stalled result is held in the output register while
// one more result fits in the skid stage; chars.ready drops only while that
// skid stage is full.
module number_literal_parser_top #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                clk,
  input logic                rst,
  nlp_char_if.sink           chars,
  nlp_result_if.source       result
);
  import nlp_pkg::*;

  res_t res;
  res_t out_res, skid_res;
  logic out_valid, skid_valid;
  logic take, take_end;

  assign chars.ready = !skid_valid;
  assign take        = chars.valid && chars.ready;
  assign take_end    = take && chars.is_end;

  nlp_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .ch     (chars.ch),
    .is_end (chars.is_end),
    .res    (res)
  );

  // Output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !result.ready) begin
      if (take_end) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= take_end;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (out_valid && !result.ready) begin
      if (take_end) begin
        skid_res <= res;
      end
    end else if (skid_valid) begin
      out_res <= skid_res;
    end else if (take_end) begin
      out_res <= res;
    end
  end

  assign result.valid  = out_valid;
  assign result.value  = out_res.value;
  assign result.format = out_res.format;

  // Skid stage is only occupied behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full with output register empty");

  // An end transfer always yields a waiting result next cycle
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    take_end |=> out_valid)
    else $error("end transfer produced no result");

  // An end transfer behind a stalled result lands in the skid stage
  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (take_end && out_valid && !result.ready) |=> skid_valid)
    else $error("result lost behind a stalled output");

  // Draining the skid stage keeps a result on the output
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && result.ready) |=> (out_valid && !skid_valid))
    else $error("skid stage not moved to output");

endmodule

// ===== tb/number_literal_parser_top_test.sv =====
// Testbench for number_literal_parser_top: directed and random literals checked against a parse predictor.
module number_literal_parser_top_test;
  import nlp_pkg::*;

  typedef logic [7:0] text_q_t[$];

  localparam int CYCLE_LIMIT = 100000;
  localparam int RANDOM_ITEMS = 600;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst;

  nlp_char_if   chars();
  nlp_result_if result();

  number_literal_parser_top DUT (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .result (result)
  );

  always #2 clk = ~clk;

  // Results still owed by the block, oldest first
  res_t        pending_results[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned random_items = 0;
  bit          quiet = 1'b0;

  // Predicted parser state
  phase_t      lit_phase;
  logic        lit_neg;
  logic [7:0]  lit_held;
  prefix_t     lit_prefix;
  logic [31:0] dec_acc;
  logic        dec_stop;
  logic [31:0] hex_acc;
  logic        hex_stop;
  logic        suffix_seen;
  logic        prev_h;

  function bit is_alnum_ch(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_A_LO && c <= CH_Z_LO) ||
           (c >= CH_A_UP && c <= CH_Z_UP);
  endfunction

  function bit is_h_ch(input logic [7:0] c);
    return c == CH_H_LO || c == CH_H_UP;
  endfunction

  function void clear_literal();
    lit_phase   = PH_START;
    lit_neg     = 1'b0;
    lit_held    = CH_NUL;
    lit_prefix  = PK_NONE;
    dec_acc     = '0;
    dec_stop    = 1'b0;
    hex_acc     = '0;
    hex_stop    = 1'b0;
    suffix_seen = 1'b0;
    prev_h      = 1'b0;
  endfunction

  // Feed one body character to both the decimal and the hex reading
  function void accumulate(input logic [7:0] c);
    logic [3:0] d;
    bit         hex_ok;
    if (!dec_stop) begin
      if (c >= CH_ZERO && c <= CH_NINE)
        dec_acc = dec_acc * 32'd10 + 32'(c - CH_ZERO);
      else
        dec_stop = 1'b1;
    end
    hex_ok = 1'b1;
    d = '0;
    if (c >= CH_ZERO && c <= CH_NINE) d = 4'(c - CH_ZERO);
    else if (c >= CH_A_LO && c <= CH_F_LO) d = 4'(c - CH_A_LO + 8'd10);
    else if (c >= CH_A_UP && c <= CH_F_UP) d = 4'(c - CH_A_UP + 8'd10);
    else hex_ok = 1'b0;
    if (!hex_stop) begin
      if (hex_ok)
        hex_acc = {hex_acc[27:0], d};
      else
        hex_stop = 1'b1;
    end
    if (prev_h && !is_alnum_ch(c))
      suffix_seen = 1'b1;
    prev_h = is_h_ch(c);
  endfunction

  // First character after an optional sign
  function void take_first(input logic [7:0] c);
    if (c == CH_DOLLAR) begin
      lit_prefix = PK_DOLLAR;
      lit_phase  = PH_BODY;
    end else if (c == CH_ZERO || c == CH_AMP) begin
      lit_held = c;
      accumulate(c);
      lit_phase = PH_SECOND;
    end else begin
      accumulate(c);
      lit_phase = PH_BODY;
    end
  endfunction

  // Advance the predicted parser by one item; returns 1 when a result is due
  function bit parse_item(input logic [7:0] c, input bit last, output res_t r);
    logic [31:0] v;
    format_t     f;
    r = '0;
    if (last) begin
      if (lit_prefix != PK_NONE) begin
        v = hex_acc;
        case (lit_prefix)
          PK_0X:   f = FMT_0X;
          PK_AMPH: f = FMT_AMPH;
          default: f = FMT_DOLLAR;
        endcase
      end else if (suffix_seen || prev_h) begin
        v = hex_acc;
        f = FMT_SUFFIX;
      end else begin
        v = dec_acc;
        f = FMT_DEC;
      end
      if (lit_neg)
        v = -v;
      r.value  = v;
      r.format = f;
      clear_literal();
      return 1'b1;
    end
    if (lit_phase == PH_DONE)
      return 1'b0;
    // a zero byte ends the text; the rest up to the end item is ignored
    if (c == CH_NUL) begin
      lit_phase = PH_DONE;
      return 1'b0;
    end
    case (lit_phase)
      PH_START: begin
        if (c == CH_MINUS) begin
          lit_neg   = 1'b1;
          lit_phase = PH_FIRST;
        end else begin
          take_first(c);
        end
      end
      PH_FIRST: take_first(c);
      PH_SECOND: begin
        if ((lit_held == CH_ZERO && (c == CH_X_LO || c == CH_X_UP)) ||
            (lit_held == CH_AMP && is_h_ch(c))) begin
          if (lit_held == CH_ZERO)
            lit_prefix = PK_0X;
          else
            lit_prefix = PK_AMPH;
          hex_acc  = '0;
          hex_stop = 1'b0;
        end else begin
          accumulate(c);
        end
        lit_phase = PH_BODY;
      end
      default: accumulate(c);
    endcase
    return 1'b0;
  endfunction

  // Send one item: random gap, then hold valid until the transfer
  task send_char(input logic [7:0] c, input bit last);
    int unsigned gap;
    res_t        r;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      chars.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars.valid  <= 1'b1;
    chars.ch     <= c;
    chars.is_end <= last;
    @(posedge clk);
    while (!chars.ready) @(posedge clk);
    if (parse_item(c, last, r))
      pending_results = {pending_results, r};
  endtask

  task send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], 1'b0);
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function logic [7:0] hex_char(input int d);
    if (d < 10)
      return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CH_A_UP : CH_A_LO) + 8'(d - 10);
  endfunction

  function logic [7:0] non_alnum_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (is_alnum_ch(c))
      c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  // Mostly well-formed literals of each format, with some noise mixed in
  function void build_literal(output text_q_t text);
    int         kind;
    int         len;
    logic [7:0] c;
    text = {};
    kind = $urandom_range(0, 5);
    if ($urandom_range(0, 9) < 3)
      text = {text, CH_MINUS};
    case (kind)
      1: begin
        text = {text, CH_ZERO};
        text = {text, ($urandom_range(0, 1) ? CH_X_UP : CH_X_LO)};
      end
      2: begin
        text = {text, CH_AMP};
        text = {text, ($urandom_range(0, 1) ? CH_H_UP : CH_H_LO)};
      end
      3: text = {text, CH_DOLLAR};
      default: ;
    endcase
    // long bodies wrap the accumulators
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
    if (kind == 5 && len == 0)
      len = 1;
    for (int i = 0; i < len; i++) begin
      if (kind == 5)
        c = 8'($urandom_range(0, 255));
      else if (kind == 0)
        c = CH_ZERO + 8'($urandom_range(0, 9));
      else
        c = hex_char($urandom_range(0, 15));
      text = {text, c};
    end
    if (kind == 4) begin
      text = {text, ($urandom_range(0, 1) ? CH_H_UP : CH_H_LO)};
      case ($urandom_range(0, 3))
        1: text = {text, non_alnum_char()};
        2: text = {text, CH_ZERO + 8'($urandom_range(0, 9))};
        3: begin
          text = {text, non_alnum_char()};
          text = {text, CH_ZERO + 8'($urandom_range(0, 9))};
        end
        default: ;
      endcase
    end
    // stray byte or zero byte somewhere in the text
    if (text.size() > 0 && $urandom_range(0, 9) == 0)
      text.insert($urandom_range(0, text.size() - 1), 8'($urandom_range(0, 255)));
    if (text.size() > 0 && $urandom_range(0, 19) == 0)
      text.insert($urandom_range(0, text.size() - 1), CH_NUL);
  endfunction

  task test_empty_and_minus();
    send_text("");
    send_text("-");
  endtask

  task test_prefixes();
    send_text("-0xF");
    send_text("&H");
    send_text("$fF");
  endtask

  task test_suffix_and_minus_inside();
    send_text("9h-");
  endtask

  task test_zero_byte();
    send_char(CH_ZERO + 8'd8, 1'b0);
    send_char(CH_NUL, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'hff, 1'b1);
  endtask

  task test_random_literals();
    text_q_t text;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0)
        quiet = !quiet;
      build_literal(text);
      foreach (text[i])
        send_char(text[i], 1'b0);
      send_char(8'($urandom_range(0, 255)), 1'b1);
      random_items += text.size() + 1;
    end
    quiet = 1'b0;
  endtask

  // Result side: random stalls, and each transfer checked against the oldest prediction
  always @(posedge clk) begin : result_side
    int unsigned hold_cnt;
    int unsigned w;
    res_t        want;
    if (rst) begin
      result.ready <= 1'b0;
      hold_cnt = 0;
    end else if (result.valid && result.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value %0d format %0d", $time,
                 result.value, result.format);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.value !== want.value || result.format !== want.format) begin
          $display("%0t: mismatch: expected value %0d format %0d, actual value %0d format %0d",
                   $time, want.value, want.format, result.value, result.format);
          error_count++;
        end
      end
      w = quiet ? 0 : $urandom_range(0, 9);
      if (w == 0) begin
        result.ready <= 1'b1;
      end else begin
        result.ready <= 1'b0;
        hold_cnt = w;
      end
    end else if (hold_cnt > 1) begin
      hold_cnt--;
    end else begin
      hold_cnt = 0;
      result.ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    chars.valid  = 1'b0;
    chars.ch     = '0;
    chars.is_end = 1'b0;
    clear_literal();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_minus();
    test_prefixes();
    test_suffix_and_minus_inside();
    test_zero_byte();
    test_random_literals();
    chars.valid <= 1'b0;

    // drain the outstanding results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
